>>> hw/rtl/lrfc_pkg.sv
// Package for the link response frame checker.
// Holds the item and result types, the phase and code enums, the CRC16
// byte update function and the block constants. Depends on nothing.
package lrfc_pkg;

  // Frame layout and limits.
  localparam int MAX_FRAME_BYTES_DEF = 96;
  localparam int MAX_WRITE_BYTES     = 32;
  localparam int FRAME_MIN           = 8;
  localparam int DATA_START          = 6;

  // CRC16: reflected form of polynomial 0xA2EB, init all ones, no final xor.
  localparam logic [15:0] CRC_POLY_REFL = 16'hD745;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;

  // Configuration register reset values.
  localparam logic [7:0]  READ_TYPE_RST   = 8'd130;
  localparam logic [7:0]  WRITE_TYPE_RST  = 8'd129;
  localparam logic [15:0] HDR_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] PL_TIMEOUT_RST  = 16'd500;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_TYPE   = 2'd0,
    CFG_WRITE_TYPE  = 2'd1,
    CFG_HDR_TIMEOUT = 2'd2,
    CFG_PL_TIMEOUT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_TIMEOUT = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  // Configuration registers as seen by the engine.
  typedef struct packed {
    logic [7:0]  read_type;
    logic [7:0]  write_type;
    logic [15:0] hdr_timeout;
    logic [15:0] pl_timeout;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic [1:0]  mode;
    logic        kind;
    logic [15:0] expected_address;
    logic [7:0]  expected_length;
    logic [7:0]  rx_byte;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic       done_res;
    logic [1:0] verdict;
  } res_t;

  // Bitwise CRC16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {8'h00, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/lrfc_if.sv
// Channel interfaces for the link response frame checker.
// Input and result channels with valid/ready handshake; uses no package.
interface lrfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        kind;
  logic [15:0] expected_address;
  logic [7:0]  expected_length;
  logic [7:0]  rx_byte;

  modport source (output valid, mode, kind, expected_address, expected_length, rx_byte,
                  input ready);
  modport sink   (input valid, mode, kind, expected_address, expected_length, rx_byte,
                  output ready);
endinterface

interface lrfc_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [6:0] data_index;
  logic       done_res;
  logic [1:0] verdict;

  modport source (output valid, data_valid, data_byte, data_index, done_res, verdict,
                  input ready);
  modport sink   (input valid, data_valid, data_byte, data_index, done_res, verdict,
                  output ready);
endinterface

>>> hw/rtl/lrfc_engine.sv
// Frame checking engine: transaction state, CRC, field checks and deadlines.
// Turns one registered request into one result combinationally.
// Depends on lrfc_pkg.
module lrfc_engine #(
  parameter int MAX_FRAME_BYTES = lrfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lrfc_pkg::in_item_t item,
  input  lrfc_pkg::cfg_t     cfg,
  output lrfc_pkg::res_t     res
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  lrfc_pkg::phase_t  phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       ticks_r, ticks_nxt;
  logic              mism_r, mism_nxt;
  logic              kind_r, kind_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic [7:0]        len_r, len_nxt;

  lrfc_pkg::mode_t   mode;
  logic [15:0]       crc_upd;
  logic [7:0]        want_type;
  logic [8:0]        min_total;
  logic              hdr_bad;
  logic [POS_W:0]    pos_inc;
  logic              frame_end;
  logic              data_pass;
  logic              mism_pl;
  logic [15:0]       ticks_inc;
  logic [15:0]       limit;
  logic              tick_hit;
  logic              start_oversize;

  // Decode of the request against the current state.
  always_comb begin
    mode      = lrfc_pkg::mode_t'(item.mode);
    crc_upd   = lrfc_pkg::crc_byte(crc_r, item.rx_byte);
    want_type = kind_r ? cfg.write_type : cfg.read_type;
    min_total = {1'b0, len_r} + 9'(lrfc_pkg::FRAME_MIN);
    if (!kind_r) begin
      hdr_bad = mism_r || ({1'b0, item.rx_byte} < min_total) ||
                ({1'b0, item.rx_byte} > 9'(MAX_FRAME_BYTES));
    end else begin
      hdr_bad = mism_r || (item.rx_byte != 8'(lrfc_pkg::FRAME_MIN));
    end
    pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
    frame_end = pos_inc >= {1'b0, total_r};
    data_pass = !kind_r && (pos_r >= POS_W'(lrfc_pkg::DATA_START)) &&
                (({1'b0, pos_r} + (POS_W+1)'(2)) < {1'b0, total_r});
    mism_pl   = mism_r ||
                ((pos_r == POS_W'(2)) && (item.rx_byte != 8'h00)) ||
                ((pos_r == POS_W'(3)) && (item.rx_byte != addr_r[7:0])) ||
                ((pos_r == POS_W'(4)) && (item.rx_byte != addr_r[15:8])) ||
                ((pos_r == POS_W'(5)) && (item.rx_byte != len_r));
    ticks_inc = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
    limit     = (phase_r == lrfc_pkg::PH_HEADER) ? cfg.hdr_timeout : cfg.pl_timeout;
    tick_hit  = ticks_inc >= limit;
    start_oversize = item.kind &&
                     (item.expected_length > 8'(lrfc_pkg::MAX_WRITE_BYTES));
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    crc_nxt   = crc_r;
    ticks_nxt = ticks_r;
    mism_nxt  = mism_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    case (mode)
      lrfc_pkg::MODE_START: begin
        kind_nxt  = item.kind;
        addr_nxt  = item.expected_address;
        len_nxt   = item.expected_length;
        pos_nxt   = '0;
        total_nxt = '0;
        crc_nxt   = lrfc_pkg::CRC_INIT;
        ticks_nxt = '0;
        mism_nxt  = 1'b0;
        if (start_oversize || (cfg.hdr_timeout == 16'd0)) begin
          phase_nxt = lrfc_pkg::PH_IDLE;
        end else begin
          phase_nxt = lrfc_pkg::PH_HEADER;
        end
      end
      lrfc_pkg::MODE_BYTE: begin
        case (phase_r)
          lrfc_pkg::PH_HEADER: begin
            crc_nxt = crc_upd;
            if (pos_r == '0) begin
              mism_nxt = item.rx_byte != want_type;
              pos_nxt  = POS_W'(1);
            end else begin
              mism_nxt = 1'b0;
              if (hdr_bad) begin
                phase_nxt = lrfc_pkg::PH_IDLE;
              end else begin
                total_nxt = POS_W'(item.rx_byte);
                pos_nxt   = POS_W'(2);
                ticks_nxt = '0;
                phase_nxt = (cfg.pl_timeout == 16'd0) ? lrfc_pkg::PH_IDLE
                                                       : lrfc_pkg::PH_PAYLOAD;
              end
            end
          end
          lrfc_pkg::PH_PAYLOAD: begin
            crc_nxt  = crc_upd;
            mism_nxt = mism_pl;
            pos_nxt  = pos_inc[POS_W-1:0];
            if (frame_end) begin
              phase_nxt = lrfc_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      lrfc_pkg::MODE_TICK: begin
        if (phase_r != lrfc_pkg::PH_IDLE) begin
          ticks_nxt = ticks_inc;
          if (tick_hit) begin
            phase_nxt = lrfc_pkg::PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result of the request.
  always_comb begin
    res = '0;
    case (mode)
      lrfc_pkg::MODE_START: begin
        if (start_oversize) begin
          res.done_res = 1'b1;
          res.verdict  = lrfc_pkg::VERDICT_INVALID;
        end else if (cfg.hdr_timeout == 16'd0) begin
          res.done_res = 1'b1;
          res.verdict  = lrfc_pkg::VERDICT_TIMEOUT;
        end
      end
      lrfc_pkg::MODE_BYTE: begin
        case (phase_r)
          lrfc_pkg::PH_HEADER: begin
            if (pos_r != '0) begin
              if (hdr_bad) begin
                res.done_res = 1'b1;
                res.verdict  = lrfc_pkg::VERDICT_INVALID;
              end else if (cfg.pl_timeout == 16'd0) begin
                res.done_res = 1'b1;
                res.verdict  = lrfc_pkg::VERDICT_TIMEOUT;
              end
            end
          end
          lrfc_pkg::PH_PAYLOAD: begin
            if (data_pass) begin
              res.data_valid = 1'b1;
              res.data_byte  = item.rx_byte;
              res.data_index = 7'(8'(pos_r) - 8'(lrfc_pkg::DATA_START));
            end
            if (frame_end) begin
              res.done_res = 1'b1;
              res.verdict  = ((crc_upd != 16'h0000) || mism_pl) ? lrfc_pkg::VERDICT_INVALID
                                                                : lrfc_pkg::VERDICT_OK;
            end
          end
          default: begin
          end
        endcase
      end
      lrfc_pkg::MODE_TICK: begin
        if ((phase_r != lrfc_pkg::PH_IDLE) && tick_hit) begin
          res.done_res = 1'b1;
          res.verdict  = lrfc_pkg::VERDICT_TIMEOUT;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lrfc_pkg::PH_IDLE;
      pos_r   <= '0;
      total_r <= '0;
      crc_r   <= lrfc_pkg::CRC_INIT;
      ticks_r <= '0;
      mism_r  <= 1'b0;
      kind_r  <= 1'b0;
      addr_r  <= '0;
      len_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      crc_r   <= crc_nxt;
      ticks_r <= ticks_nxt;
      mism_r  <= mism_nxt;
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
    end
  end

  // A finished transaction leaves the engine idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |=> phase_r == lrfc_pkg::PH_IDLE)
    else $error("engine not idle after a verdict");

  // The last byte of a frame is never passed through as data.
  a_data_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(res.data_valid && res.done_res))
    else $error("data byte reported together with a verdict");

  // A verdict code only appears with done.
  a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.done_res |-> res.verdict == lrfc_pkg::VERDICT_OK)
    else $error("verdict set without done");

  // In the payload the position stays inside the announced total.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lrfc_pkg::PH_PAYLOAD |-> (pos_r < total_r) && (pos_r >= POS_W'(2)))
    else $error("payload position outside the frame");

endmodule

>>> hw/rtl/link_response_frame_checker.sv
// Top level of the link response frame checker.
// Input register, configuration registers, engine and result register.
// Depends on lrfc_pkg, lrfc_if and lrfc_engine.
//
// The checker takes one request per clock cycle (start, received byte or
// millisecond tick) while its results drain, and returns exactly one result
// per request: the request waits in the input register, then the byte-wise
// CRC16 update and field checks run on the way to the result
// register. A request is accepted while an earlier result still waits on the
// output. Read data bytes are flagged as they pass; the caller keeps them only
// when the final verdict is ok. Configuration writes take effect at once and
// should be made while no request is in flight. No clearing pass follows reset.
module link_response_frame_checker #(
  parameter int MAX_FRAME_BYTES = lrfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lrfc_in_if.sink                        in_ch,
  lrfc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lrfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic               in_valid_r;
  lrfc_pkg::in_item_t in_item_r;
  logic               out_valid_r;
  lrfc_pkg::res_t     out_res_r;
  lrfc_pkg::res_t     res;
  lrfc_pkg::cfg_t     cfg_r;
  logic               advance;
  logic               in_fire;

  // The input register moves on when the result register is free or drains.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.mode             <= in_ch.mode;
      in_item_r.kind             <= in_ch.kind;
      in_item_r.expected_address <= in_ch.expected_address;
      in_item_r.expected_length  <= in_ch.expected_length;
      in_item_r.rx_byte          <= in_ch.rx_byte;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_type   <= lrfc_pkg::READ_TYPE_RST;
      cfg_r.write_type  <= lrfc_pkg::WRITE_TYPE_RST;
      cfg_r.hdr_timeout <= lrfc_pkg::HDR_TIMEOUT_RST;
      cfg_r.pl_timeout  <= lrfc_pkg::PL_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (lrfc_pkg::cfg_idx_t'(cfg_index))
        lrfc_pkg::CFG_READ_TYPE:   cfg_r.read_type   <= cfg_wdata[7:0];
        lrfc_pkg::CFG_WRITE_TYPE:  cfg_r.write_type  <= cfg_wdata[7:0];
        lrfc_pkg::CFG_HDR_TIMEOUT: cfg_r.hdr_timeout <= cfg_wdata;
        lrfc_pkg::CFG_PL_TIMEOUT:  cfg_r.pl_timeout  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lrfc_engine #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_valid = out_res_r.data_valid;
  assign out_ch.data_byte  = out_res_r.data_byte;
  assign out_ch.data_index = out_res_r.data_index;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.verdict    = out_res_r.verdict;

endmodule

>>> tb/link_response_frame_checker_tb.sv
// Testbench for link_response_frame_checker: drives start, byte and tick requests,
// predicts every result in a scoreboard class and checks each result field by field.
// Depends on lrfc_pkg, the lrfc_in_if and lrfc_out_if interfaces and the checker RTL.
module link_response_frame_checker_tb;

  localparam int          FRAME_LIMIT  = 96;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1800;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [15:0] POLY_NORMAL  = 16'hA2EB;

  // Frame checker predictor and result store.
  class frame_scoreboard;
    lrfc_pkg::cfg_t     cfg;
    lrfc_pkg::phase_t   ph;
    logic [6:0]         pos;
    logic [6:0]         total;
    logic [15:0]        crc;
    logic [15:0]        ticks;
    logic               mism;
    logic               kind;
    logic [15:0]        addr;
    logic [7:0]         len;
    logic [15:0]        poly_refl;
    lrfc_pkg::res_t     expected_q[$];
    int                 errors;
    int                 checked;
    int                 verdict_count[3];
    int                 data_seen;

    function new();
      int i;
      for (i = 0; i < 16; i++) poly_refl[15 - i] = POLY_NORMAL[i];
      cfg.read_type   = lrfc_pkg::READ_TYPE_RST;
      cfg.write_type  = lrfc_pkg::WRITE_TYPE_RST;
      cfg.hdr_timeout = lrfc_pkg::HDR_TIMEOUT_RST;
      cfg.pl_timeout  = lrfc_pkg::PL_TIMEOUT_RST;
      ph    = lrfc_pkg::PH_IDLE;
      pos   = '0;
      total = '0;
      crc   = lrfc_pkg::CRC_INIT;
      ticks = '0;
      mism  = 1'b0;
      kind  = 1'b0;
      addr  = '0;
      len   = '0;
    endfunction

    function void set_reg(lrfc_pkg::cfg_idx_t idx, logic [15:0] v);
      case (idx)
        lrfc_pkg::CFG_READ_TYPE:   cfg.read_type   = v[7:0];
        lrfc_pkg::CFG_WRITE_TYPE:  cfg.write_type  = v[7:0];
        lrfc_pkg::CFG_HDR_TIMEOUT: cfg.hdr_timeout = v;
        lrfc_pkg::CFG_PL_TIMEOUT:  cfg.pl_timeout  = v;
        default: ;
      endcase
    endfunction

    // Reflected CRC16 over one byte, least significant bit first.
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      int i;
      r = c ^ {8'h00, b};
      for (i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ poly_refl) : (r >> 1);
      return r;
    endfunction

    function void close(inout lrfc_pkg::res_t r, input lrfc_pkg::verdict_t v);
      ph        = lrfc_pkg::PH_IDLE;
      r.done_res = 1'b1;
      r.verdict  = v;
    endfunction

    // Work out the single result that one request causes.
    function lrfc_pkg::res_t predict(lrfc_pkg::in_item_t it);
      lrfc_pkg::res_t r;
      logic [7:0]     b;
      logic [15:0]    lim;
      logic           bad;
      int             p;
      r = '0;
      b = it.rx_byte;
      p = int'(pos);
      case (it.mode)
        lrfc_pkg::MODE_START: begin
          kind  = it.kind;
          addr  = it.expected_address;
          len   = it.expected_length;
          pos   = '0;
          total = '0;
          crc   = lrfc_pkg::CRC_INIT;
          ticks = '0;
          mism  = 1'b0;
          ph    = lrfc_pkg::PH_HEADER;
          if (kind && int'(len) > lrfc_pkg::MAX_WRITE_BYTES)
            close(r, lrfc_pkg::VERDICT_INVALID);
          else if (cfg.hdr_timeout == 16'd0) close(r, lrfc_pkg::VERDICT_TIMEOUT);
        end
        lrfc_pkg::MODE_BYTE: begin
          if (ph != lrfc_pkg::PH_IDLE) begin
            crc = crc_step(crc, b);
            if (ph == lrfc_pkg::PH_HEADER) begin
              if (p == 0) begin
                mism = (b != (kind ? cfg.write_type : cfg.read_type));
                pos  = 7'd1;
              end else begin
                bad = mism;
                if (!kind) begin
                  if (int'(b) < lrfc_pkg::FRAME_MIN + int'(len) || int'(b) > FRAME_LIMIT)
                    bad = 1'b1;
                end else if (int'(b) != lrfc_pkg::FRAME_MIN) begin
                  bad = 1'b1;
                end
                mism = 1'b0;
                if (bad) begin
                  close(r, lrfc_pkg::VERDICT_INVALID);
                end else begin
                  total = b[6:0];
                  pos   = 7'd2;
                  ticks = '0;
                  ph    = lrfc_pkg::PH_PAYLOAD;
                  if (cfg.pl_timeout == 16'd0) close(r, lrfc_pkg::VERDICT_TIMEOUT);
                end
              end
            end else begin
              // Echoed header fields: status must be zero, address and size must match.
              if (p == 2 && b != 8'd0) mism = 1'b1;
              if (p == 3 && b != addr[7:0]) mism = 1'b1;
              if (p == 4 && b != addr[15:8]) mism = 1'b1;
              if (p == 5 && b != len) mism = 1'b1;
              if (!kind && p >= lrfc_pkg::DATA_START && p + 2 < int'(total)) begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = 7'(p - lrfc_pkg::DATA_START);
              end
              pos = 7'(p + 1);
              if (p + 1 >= int'(total)) begin
                if (crc != 16'd0 || mism) close(r, lrfc_pkg::VERDICT_INVALID);
                else close(r, lrfc_pkg::VERDICT_OK);
              end
            end
          end
        end
        lrfc_pkg::MODE_TICK: begin
          if (ph != lrfc_pkg::PH_IDLE) begin
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            lim = (ph == lrfc_pkg::PH_HEADER) ? cfg.hdr_timeout : cfg.pl_timeout;
            if (ticks >= lim) close(r, lrfc_pkg::VERDICT_TIMEOUT);
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(lrfc_pkg::in_item_t it);
      expected_q.push_back(predict(it));
    endfunction

    task report(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
    endtask

    task check_result(lrfc_pkg::res_t got);
      lrfc_pkg::res_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no request waiting for one");
        return;
      end
      want = expected_q.pop_front();
      compare_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
      compare_field("data_byte", got.data_byte, want.data_byte);
      compare_field("data_index", 8'(got.data_index), 8'(want.data_index));
      compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
      compare_field("verdict", 8'(got.verdict), 8'(want.verdict));
      if (want.done_res) verdict_count[want.verdict]++;
      if (want.data_valid) data_seen++;
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          cycles;
  int          burst_left;
  int          busy_items;
  logic [7:0]  frame_bytes[$];

  frame_scoreboard sb = new();

  lrfc_in_if  in_ch();
  lrfc_out_if out_ch();

  link_response_frame_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each accepted result, then stall on a randomly chosen pattern.
  initial begin
    int style;
    int stall_cnt;
    lrfc_pkg::res_t got;
    style     = 0;
    stall_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.data_valid = out_ch.data_valid;
        got.data_byte  = out_ch.data_byte;
        got.data_index = out_ch.data_index;
        got.done_res   = out_ch.done_res;
        got.verdict    = out_ch.verdict;
        sb.check_result(got);
      end
      stall_cnt++;
      if (stall_cnt % 256 == 0) style = $urandom_range(0, 3);
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (stall_cnt % 9) < 6;
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic lrfc_pkg::in_item_t mk(logic [1:0] m, logic k, logic [15:0] a,
                                            logic [7:0] l, logic [7:0] b);
    lrfc_pkg::in_item_t r;
    r.mode             = m;
    r.kind             = k;
    r.expected_address = a;
    r.expected_length  = l;
    r.rx_byte          = b;
    return r;
  endfunction

  // Send one request; the sender works in bursts with random gaps between them.
  task send_req(input lrfc_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= it.mode;
    in_ch.kind             <= it.kind;
    in_ch.expected_address <= it.expected_address;
    in_ch.expected_length  <= it.expected_length;
    in_ch.rx_byte          <= it.rx_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    sb.note_request(it);
  endtask

  task send_byte(input logic [7:0] b);
    send_req(mk(lrfc_pkg::MODE_BYTE, 1'($urandom), 16'($urandom), 8'($urandom), b));
  endtask

  task send_tick();
    send_req(mk(lrfc_pkg::MODE_TICK, 1'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom)));
  endtask

  // Stop sending and wait until every expected result has come back.
  task drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back while the block is idle.
  task write_regs(input logic [7:0] rd_type, input logic [7:0] wr_type,
                  input logic [15:0] hdr_to, input logic [15:0] pl_to);
    cfg_we    <= 1'b1;
    cfg_index <= lrfc_pkg::CFG_READ_TYPE;
    cfg_wdata <= {8'h00, rd_type};
    @(posedge clk);
    cfg_index <= lrfc_pkg::CFG_WRITE_TYPE;
    cfg_wdata <= {8'h00, wr_type};
    @(posedge clk);
    cfg_index <= lrfc_pkg::CFG_HDR_TIMEOUT;
    cfg_wdata <= hdr_to;
    @(posedge clk);
    cfg_index <= lrfc_pkg::CFG_PL_TIMEOUT;
    cfg_wdata <= pl_to;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(lrfc_pkg::CFG_READ_TYPE, {8'h00, rd_type});
    sb.set_reg(lrfc_pkg::CFG_WRITE_TYPE, {8'h00, wr_type});
    sb.set_reg(lrfc_pkg::CFG_HDR_TIMEOUT, hdr_to);
    sb.set_reg(lrfc_pkg::CFG_PL_TIMEOUT, pl_to);
  endtask

  // Header and random data of a response frame, without its CRC.
  task build_frame(input logic k, input logic [15:0] a, input logic [7:0] l, input int tot);
    int i;
    frame_bytes.delete();
    frame_bytes.push_back(k ? sb.cfg.write_type : sb.cfg.read_type);
    frame_bytes.push_back(8'(tot));
    frame_bytes.push_back(8'd0);
    frame_bytes.push_back(a[7:0]);
    frame_bytes.push_back(a[15:8]);
    frame_bytes.push_back(l);
    for (i = 0; i < tot - lrfc_pkg::FRAME_MIN; i++) frame_bytes.push_back(8'($urandom));
  endtask

  // Append the CRC, low byte first, so that a clean frame leaves a zero residue.
  task seal_frame();
    logic [15:0] c;
    c = lrfc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) c = sb.crc_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  // One transaction: a start, then a frame that is clean, damaged or cut short.
  task do_transaction(input int tick_pct);
    logic        k;
    logic [15:0] a;
    logic [7:0]  l;
    int          tot;
    int          flavor;
    int          sel;
    int          cut;
    int          n;
    k = 1'($urandom_range(0, 1));
    a = 16'($urandom);
    if (k) begin
      l = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(33, 255)) : 8'($urandom_range(0, 32));
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 80) l = 8'($urandom_range(0, 12));
      else if (sel < 95) l = 8'($urandom_range(13, 88));
      else l = 8'($urandom_range(89, 255));
    end
    if (k) tot = lrfc_pkg::FRAME_MIN;
    else if (int'(l) > FRAME_LIMIT - lrfc_pkg::FRAME_MIN) tot = FRAME_LIMIT;
    else if ($urandom_range(0, 9) < 3)
      tot = $urandom_range(lrfc_pkg::FRAME_MIN + int'(l), FRAME_LIMIT);
    else tot = lrfc_pkg::FRAME_MIN + int'(l);
    build_frame(k, a, l, tot);
    flavor = $urandom_range(0, 99);
    // Field errors under a correct CRC.
    if (flavor >= 70 && flavor < 80) begin
      sel = $urandom_range(0, 5);
      if (sel == 2) frame_bytes[2] = 8'($urandom_range(1, 255));
      else if (sel == 1) frame_bytes[1] = 8'($urandom);
      else frame_bytes[sel] = frame_bytes[sel] ^ 8'($urandom_range(1, 255));
    end
    seal_frame();
    // A single bit error on the line.
    if (flavor >= 80 && flavor < 90) begin
      sel = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[sel][$urandom_range(0, 7)] ^= 1'b1;
    end
    // A frame that stops early.
    if (flavor >= 90) begin
      cut = $urandom_range(0, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    send_req(mk(lrfc_pkg::MODE_START, k, a, l, 8'($urandom)));
    n = 1;
    foreach (frame_bytes[i]) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_tick();
        n++;
      end
      send_byte(frame_bytes[i]);
      n++;
    end
    if (flavor >= 90) begin
      repeat ($urandom_range(0, 30)) begin
        send_tick();
        n++;
      end
    end
    busy_items += n;
  endtask

  // Requests that arrive outside a transaction, including the unused mode.
  task send_noise();
    case ($urandom_range(0, 2))
      0: send_byte(8'($urandom));
      1: send_tick();
      default: send_req(mk(MODE_UNUSED, 1'($urandom), 16'($urandom), 8'($urandom),
                           8'($urandom)));
    endcase
  endtask

  initial begin
    int ph_idx;
    logic [15:0] hdr_to;
    logic [15:0] pl_to;
    int tick_pct;
    burst_left             = 0;
    busy_items             = 0;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= lrfc_pkg::CFG_READ_TYPE;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= lrfc_pkg::MODE_TICK;
    in_ch.kind             <= 1'b0;
    in_ch.expected_address <= '0;
    in_ch.expected_length  <= '0;
    in_ch.rx_byte          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: idle requests, oversized write, clean write and read frames.
    send_byte(8'hFF);
    send_tick();
    send_req(mk(MODE_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 8'hFF));
    send_req(mk(lrfc_pkg::MODE_START, 1'b1, 16'hFFFF, 8'd33, 8'h00));
    build_frame(1'b1, 16'h0000, 8'd32, lrfc_pkg::FRAME_MIN);
    seal_frame();
    send_req(mk(lrfc_pkg::MODE_START, 1'b1, 16'h0000, 8'd32, 8'h00));
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    build_frame(1'b0, 16'hFFFF, 8'd2, lrfc_pkg::FRAME_MIN + 2);
    frame_bytes[6] = 8'h00;
    frame_bytes[7] = 8'hFF;
    seal_frame();
    send_req(mk(lrfc_pkg::MODE_START, 1'b0, 16'hFFFF, 8'd2, 8'hFF));
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    drain();

    // Zero header deadline: every start times out at once, unless the write is oversized.
    write_regs(8'h00, 8'hFF, 16'd0, 16'd1);
    send_req(mk(lrfc_pkg::MODE_START, 1'b0, 16'h1234, 8'd4, 8'h00));
    send_byte(8'h00);
    send_tick();
    send_req(mk(lrfc_pkg::MODE_START, 1'b1, 16'h4321, 8'd40, 8'h00));
    drain();

    // One-tick header deadline and zero payload deadline.
    write_regs(8'hFF, 8'h00, 16'd1, 16'd0);
    send_req(mk(lrfc_pkg::MODE_START, 1'b0, 16'h00FF, 8'd0, 8'h00));
    send_tick();
    send_req(mk(lrfc_pkg::MODE_START, 1'b0, 16'hFF00, 8'd0, 8'h00));
    send_byte(8'hFF);
    send_byte(8'd8);
    send_req(mk(lrfc_pkg::MODE_START, 1'b1, 16'h0F0F, 8'd1, 8'h00));
    send_byte(8'h00);
    send_byte(8'd9);
    drain();

    // Random transactions under several register settings.
    for (ph_idx = 0; ph_idx < 4; ph_idx++) begin
      if (ph_idx == 0) begin
        hdr_to   = 16'hFFFF;
        pl_to    = 16'hFFFF;
        tick_pct = 10;
      end else begin
        hdr_to   = 16'($urandom_range(2, 40));
        pl_to    = 16'($urandom_range(5, 120));
        tick_pct = 5;
      end
      if ($urandom_range(0, 1))
        write_regs(lrfc_pkg::READ_TYPE_RST, lrfc_pkg::WRITE_TYPE_RST, hdr_to, pl_to);
      else write_regs(8'($urandom), 8'($urandom), hdr_to, pl_to);
      while (busy_items < (ph_idx + 1) * (RANDOM_ITEMS / 4)) begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_noise();
        do_transaction(tick_pct);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("Checked %0d results over %0d transaction requests; %0d read data bytes seen.",
             sb.checked, busy_items, sb.data_seen);
    $display("Verdicts: %0d ok, %0d timeout, %0d invalid.",
             sb.verdict_count[lrfc_pkg::VERDICT_OK], sb.verdict_count[lrfc_pkg::VERDICT_TIMEOUT],
             sb.verdict_count[lrfc_pkg::VERDICT_INVALID]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
